### design/circular_next_free_slot_allocator_core_macros.svh
// Assertion macros for the slot allocator core.
// No dependencies; included by the top level, which supplies clk and rst_n.
`ifndef CIRCULAR_NEXT_FREE_SLOT_ALLOCATOR_CORE_MACROS_SVH
`define CIRCULAR_NEXT_FREE_SLOT_ALLOCATOR_CORE_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, sampled on clk, off during reset
`define CNFSA_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cnfsa: same-cycle check failed");
// Next-cycle implication, sampled on clk, off during reset
`define CNFSA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cnfsa: next-cycle check failed");
`else
`define CNFSA_ASSERT_NOW(label, ante, cons)
`define CNFSA_ASSERT_NEXT(label, ante, cons)
`endif

`endif

### design/cnfsa_pkg.sv
// Shared constants and types for the slot allocator core.
// No dependencies; used by cnfsa_ffs and the top level.
package cnfsa_pkg;

    localparam int MAX_SPOTS    = 1024;
    localparam int WORD_BITS    = 64;
    localparam int NUM_WORDS    = (MAX_SPOTS + WORD_BITS - 1) / WORD_BITS;
    localparam int SLOT_W       = 11;
    localparam int WORD_ADDR_W  = $clog2(NUM_WORDS);
    localparam int BIT_W        = $clog2(WORD_BITS);
    localparam int STEP_W       = $clog2(NUM_WORDS + 1);
    localparam int SPAN_W       = $clog2(NUM_WORDS * WORD_BITS) + 1;

    typedef logic [WORD_BITS-1:0] word_t;

    typedef struct packed {
        logic             found;
        logic [BIT_W-1:0] pos;
    } ffs_result_t;

endpackage

### design/circular_next_free_slot_allocator_core.sv
// Circular first-fit slot allocator: request sequencer, occupancy bitmap, result register.
// Depends on cnfsa_pkg, cnfsa_ffs and circular_next_free_slot_allocator_core_macros.svh.
//
// Usage:
//   Request: drive func/spot and raise start; it is taken at a clock edge where busy is
//   low. func 0 (enter) allocates the first free slot at or above spot, wrapping to the
//   lowest free slot; func 1 (leave) frees slot spot.
//   Result: done pulses for one cycle with assigned_spot and full_res. The receiver
//   cannot stall, so the result must be captured in that cycle.
//   Timing: an enter scans one 64-bit bitmap word per cycle through a single
//   find-first-set unit, starting at the word of the preferred slot and wrapping once;
//   done is registered when a free bit is found or when the return visit to the
//   starting word finds none. A leave frees its bit from ST_LEAVE. busy drops in the
//   cycle done is shown, so the next request can be taken at that edge.
//   Config: cfg_wr_en writes spot_count from cfg_wr_data and frees every slot. Write
//   only while busy is low.
//   Reset: spot_count returns to 1024, all slots free, no result pending.
`include "circular_next_free_slot_allocator_core_macros.svh"

module circular_next_free_slot_allocator_core
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic                           func,
    input  logic [cnfsa_pkg::SLOT_W-1:0]   spot,
    output logic                           done,
    output logic [cnfsa_pkg::SLOT_W-1:0]   assigned_spot,
    output logic                           full_res,
    input  logic                           cfg_wr_en,
    input  logic [cnfsa_pkg::SLOT_W-1:0]   cfg_wr_data
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_LEAVE = 2'd2;

    localparam int SW = cnfsa_pkg::SLOT_W;
    localparam int AW = cnfsa_pkg::WORD_ADDR_W;
    localparam int BW = cnfsa_pkg::BIT_W;
    localparam int KW = cnfsa_pkg::STEP_W;
    localparam int PW = cnfsa_pkg::SPAN_W;

    logic [1:0]         state_reg, state_next;
    logic [KW-1:0]      k_reg, k_next;
    logic [AW-1:0]      ws_reg, ws_next;
    logic [BW-1:0]      sb_reg, sb_next;
    logic [SW-1:0]      spot_reg, spot_next;
    logic               done_reg, done_next;
    logic [SW-1:0]      assigned_reg, assigned_next;
    logic               full_reg, full_next;
    logic [SW-1:0]      spot_count_reg;

    cnfsa_pkg::word_t   bitmap_reg [cnfsa_pkg::NUM_WORDS];

    logic [SW-1:0]      count_act;
    logic [SW-1:0]      start_slot;
    logic [SW-1:0]      start_idx;
    logic [AW-1:0]      start_ws;
    logic [BW-1:0]      start_sb;
    logic [KW:0]        addr_sum;
    logic [AW-1:0]      waddr;
    cnfsa_pkg::word_t   pos_low;
    cnfsa_pkg::word_t   pos_mask;
    logic [PW-1:0]      word_base;
    logic [PW-1:0]      count_ext;
    logic [PW-1:0]      remain;
    cnfsa_pkg::word_t   count_mask;
    cnfsa_pkg::word_t   free_vec;
    cnfsa_pkg::ffs_result_t ffs_res;
    logic [SW-1:0]      found_slot;
    logic [SW-1:0]      leave_idx;
    logic               leave_ok;
    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    logic [BW-1:0]      wr_bit;
    logic               wr_val;
    logic [SW-1:0]      chk_idx;
    logic               chk_taken;

    // Clamp the slot count to capacity
    assign count_act = (spot_count_reg > SW'(cnfsa_pkg::MAX_SPOTS)) ?
                       SW'(cnfsa_pkg::MAX_SPOTS) : spot_count_reg;

    // Locate the starting word and bit; wrap at once when the start is out of range
    assign start_slot = (spot == '0) ? SW'(1) : spot;
    assign start_idx  = start_slot - SW'(1);
    always_comb
    begin
        if ((count_act == '0) || (start_slot > count_act))
        begin
            start_ws = '0;
            start_sb = '0;
        end
        else
        begin
            start_ws = AW'(start_idx / cnfsa_pkg::WORD_BITS);
            start_sb = BW'(start_idx % cnfsa_pkg::WORD_BITS);
        end
    end

    // Walk the words circularly from the starting word
    assign addr_sum = (KW + 1)'(ws_reg) + (KW + 1)'(k_reg);
    assign waddr    = (addr_sum >= (KW + 1)'(cnfsa_pkg::NUM_WORDS)) ?
                      AW'(addr_sum - (KW + 1)'(cnfsa_pkg::NUM_WORDS)) : AW'(addr_sum);

    // Keep bits at or above the start on the first visit, below it on the return visit
    assign pos_low = (cnfsa_pkg::word_t'(1) << sb_reg) - cnfsa_pkg::word_t'(1);
    always_comb
    begin
        if (k_reg == '0)
            pos_mask = ~pos_low;
        else if (k_reg == KW'(cnfsa_pkg::NUM_WORDS))
            pos_mask = pos_low;
        else
            pos_mask = '1;
    end

    // Drop bits of slots beyond the active count
    assign word_base = PW'(waddr) * PW'(cnfsa_pkg::WORD_BITS);
    assign count_ext = PW'(count_act);
    assign remain    = count_ext - word_base;
    always_comb
    begin
        if (count_ext <= word_base)
            count_mask = '0;
        else if (remain >= PW'(cnfsa_pkg::WORD_BITS))
            count_mask = '1;
        else
            count_mask = (cnfsa_pkg::word_t'(1) << remain[BW-1:0]) - cnfsa_pkg::word_t'(1);
    end

    assign free_vec = ~bitmap_reg[waddr] & pos_mask & count_mask;

    cnfsa_ffs u_ffs
    (
        .vec (free_vec),
        .res (ffs_res)
    );

    assign found_slot = SW'(word_base) + SW'(ffs_res.pos) + SW'(1);

    // Leave target: only slots 1..count are freed
    assign leave_idx = spot_reg - SW'(1);
    assign leave_ok  = (spot_reg != '0) && (spot_reg <= count_act);

    // Sequence the request
    always_comb
    begin
        state_next    = state_reg;
        k_next        = k_reg;
        ws_next       = ws_reg;
        sb_next       = sb_reg;
        spot_next     = spot_reg;
        done_next     = 1'b0;
        assigned_next = assigned_reg;
        full_next     = full_reg;
        wr_en         = 1'b0;
        wr_addr       = waddr;
        wr_bit        = ffs_res.pos;
        wr_val        = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    spot_next  = spot;
                    k_next     = '0;
                    ws_next    = start_ws;
                    sb_next    = start_sb;
                    state_next = func ? ST_LEAVE : ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (ffs_res.found)
                begin
                    wr_en         = 1'b1;
                    done_next     = 1'b1;
                    assigned_next = found_slot;
                    full_next     = 1'b0;
                    state_next    = ST_IDLE;
                end
                else if (k_reg == KW'(cnfsa_pkg::NUM_WORDS))
                begin
                    done_next     = 1'b1;
                    assigned_next = '0;
                    full_next     = 1'b1;
                    state_next    = ST_IDLE;
                end
                else
                begin
                    k_next = k_reg + KW'(1);
                end
            end
            ST_LEAVE:
            begin
                wr_en         = leave_ok;
                wr_addr       = AW'(leave_idx / cnfsa_pkg::WORD_BITS);
                wr_bit        = BW'(leave_idx % cnfsa_pkg::WORD_BITS);
                wr_val        = 1'b0;
                done_next     = 1'b1;
                assigned_next = '0;
                full_next     = 1'b0;
                state_next    = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state and the count register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            k_reg          <= '0;
            done_reg       <= 1'b0;
            spot_count_reg <= SW'(cnfsa_pkg::MAX_SPOTS);
        end
        else
        begin
            state_reg <= state_next;
            k_reg     <= k_next;
            done_reg  <= done_next;
            if (cfg_wr_en)
                spot_count_reg <= cfg_wr_data;
        end
    end

    // Request payload and result
    always_ff @(posedge clk)
    begin
        ws_reg       <= ws_next;
        sb_reg       <= sb_next;
        spot_reg     <= spot_next;
        assigned_reg <= assigned_next;
        full_reg     <= full_next;
    end

    // Occupancy bitmap: free everything on reset and on a count write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int w = 0; w < cnfsa_pkg::NUM_WORDS; w++)
                bitmap_reg[w] <= '0;
        end
        else if (cfg_wr_en)
        begin
            for (int w = 0; w < cnfsa_pkg::NUM_WORDS; w++)
                bitmap_reg[w] <= '0;
        end
        else if (wr_en)
        begin
            bitmap_reg[wr_addr][wr_bit] <= wr_val;
        end
    end

    assign busy          = (state_reg != ST_IDLE);
    assign done          = done_reg;
    assign assigned_spot = assigned_reg;
    assign full_res      = full_reg;

    // Bitmap bit of the slot just handed out
    assign chk_idx   = assigned_reg - SW'(1);
    assign chk_taken = bitmap_reg[AW'(chk_idx / cnfsa_pkg::WORD_BITS)]
                                 [BW'(chk_idx % cnfsa_pkg::WORD_BITS)];

    `CNFSA_ASSERT_NEXT(a_accept_goes_busy, start && !busy, busy)
    `CNFSA_ASSERT_NOW(a_done_releases, done_reg, !busy)
    `CNFSA_ASSERT_NOW(a_slot_in_range, done_reg && (assigned_reg != '0), !full_reg && (assigned_reg <= count_act))
    `CNFSA_ASSERT_NOW(a_slot_marked, done_reg && (assigned_reg != '0), chk_taken)

endmodule

### design/cnfsa_ffs.sv
// Find-first-set over one bitmap word: lowest set bit and a found flag.
// Depends on cnfsa_pkg.
module cnfsa_ffs
(
    input  cnfsa_pkg::word_t       vec,
    output cnfsa_pkg::ffs_result_t res
);

    // Halve the window each level: take the low half if it holds a set bit
    always_comb
    begin
        cnfsa_pkg::word_t               v;
        cnfsa_pkg::word_t               low_mask;
        logic [cnfsa_pkg::BIT_W-1:0]    p;
        int                             half;
        v        = vec;
        p        = '0;
        low_mask = '0;
        half     = 0;
        for (int lvl = cnfsa_pkg::BIT_W - 1; lvl >= 0; lvl--)
        begin
            half     = 1 << lvl;
            low_mask = (cnfsa_pkg::word_t'(1) << half) - cnfsa_pkg::word_t'(1);
            if ((v & low_mask) == '0)
            begin
                p[lvl] = 1'b1;
                v      = v >> half;
            end
        end
        res.found = |vec;
        res.pos   = p;
    end

endmodule

### tb/sv/tb_circular_next_free_slot_allocator_core.sv
// Self-checking testbench for the circular first-fit slot allocator core.
// Depends on cnfsa_pkg and circular_next_free_slot_allocator_core; runs stand-alone.
// Runs a directed table of requests, then random phases under several slot counts.
`timescale 1ns / 100ps

module tb_circular_next_free_slot_allocator_core;

    import cnfsa_pkg::*;

    localparam logic FUNC_ENTER = 1'b0;
    localparam logic FUNC_LEAVE = 1'b1;
    localparam int   CLK_HALF   = 10;
    localparam int   DRAIN_WAIT = 24;

    typedef enum logic {ROW_REQUEST, ROW_CONFIG} row_kind_t;

    // One directed step: a request with its typed grant, or a spot_count write
    typedef struct packed {
        row_kind_t         kind;
        logic              func;
        logic [SLOT_W-1:0] spot;
        logic [SLOT_W-1:0] exp_spot;
        logic              exp_full;
    } step_row_t;

    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        logic              full;
    } grant_t;

    // Random phase: slot count (-1 picks one at random), request total, enter share
    typedef struct {
        int count;
        int items;
        int enter_pct;
    } phase_t;

    logic              clk;
    logic              rst_n;
    logic              start;
    logic              busy;
    logic              func;
    logic [SLOT_W-1:0] spot;
    logic              done;
    logic [SLOT_W-1:0] assigned_spot;
    logic              full_res;
    logic              cfg_wr_en;
    logic [SLOT_W-1:0] cfg_wr_data;

    // Predictor state: configured count and one taken flag per slot
    logic [SLOT_W-1:0] spot_limit;
    bit [MAX_SPOTS:1]  slot_used;
    grant_t            expected_grants[$];
    int                mismatches;

    step_row_t directed_rows [29] = '{
        '{ROW_REQUEST, FUNC_ENTER, 11'd1,    11'd1,    1'b0},
        '{ROW_REQUEST, FUNC_ENTER, 11'd1,    11'd2,    1'b0},
        '{ROW_REQUEST, FUNC_ENTER, 11'd0,    11'd3,    1'b0},
        '{ROW_REQUEST, FUNC_ENTER, 11'd1024, 11'd1024, 1'b0},
        '{ROW_REQUEST, FUNC_ENTER, 11'd1024, 11'd4,    1'b0},
        '{ROW_REQUEST, FUNC_ENTER, 11'd2047, 11'd5,    1'b0},
        '{ROW_REQUEST, FUNC_LEAVE, 11'd1024, 11'd0,    1'b0},
        '{ROW_REQUEST, FUNC_LEAVE, 11'd1024, 11'd0,    1'b0},
        '{ROW_REQUEST, FUNC_LEAVE, 11'd0,    11'd0,    1'b0},
        '{ROW_REQUEST, FUNC_LEAVE, 11'd2047, 11'd0,    1'b0},
        '{ROW_REQUEST, FUNC_ENTER, 11'd64,   11'd64,   1'b0},
        '{ROW_REQUEST, FUNC_ENTER, 11'd63,   11'd63,   1'b0},
        '{ROW_REQUEST, FUNC_ENTER, 11'd63,   11'd65,   1'b0},
        '{ROW_REQUEST, FUNC_LEAVE, 11'd2,    11'd0,    1'b0},
        '{ROW_REQUEST, FUNC_ENTER, 11'd1024, 11'd1024, 1'b0},
        '{ROW_REQUEST, FUNC_ENTER, 11'd1024, 11'd2,    1'b0},
        '{ROW_CONFIG,  FUNC_ENTER, 11'd1,    11'd0,    1'b0},
        '{ROW_REQUEST, FUNC_ENTER, 11'd5,    11'd1,    1'b0},
        '{ROW_REQUEST, FUNC_ENTER, 11'd1,    11'd0,    1'b1},
        '{ROW_REQUEST, FUNC_LEAVE, 11'd1,    11'd0,    1'b0},
        '{ROW_REQUEST, FUNC_ENTER, 11'd0,    11'd1,    1'b0},
        '{ROW_CONFIG,  FUNC_ENTER, 11'd0,    11'd0,    1'b0},
        '{ROW_REQUEST, FUNC_ENTER, 11'd1,    11'd0,    1'b1},
        '{ROW_REQUEST, FUNC_LEAVE, 11'd1,    11'd0,    1'b0},
        '{ROW_CONFIG,  FUNC_ENTER, 11'd2047, 11'd0,    1'b0},
        '{ROW_REQUEST, FUNC_ENTER, 11'd2047, 11'd1,    1'b0},
        '{ROW_REQUEST, FUNC_ENTER, 11'd1025, 11'd2,    1'b0},
        '{ROW_REQUEST, FUNC_LEAVE, 11'd1025, 11'd0,    1'b0},
        '{ROW_REQUEST, FUNC_ENTER, 11'd1,    11'd3,    1'b0}
    };

    phase_t phases [13] = '{
        '{1,    60,  50},
        '{2,    80,  55},
        '{3,    80,  60},
        '{63,   120, 65},
        '{64,   120, 70},
        '{65,   120, 70},
        '{130,  260, 85},
        '{0,    30,  60},
        '{1024, 200, 60},
        '{700,  100, 55},
        '{2047, 100, 60},
        '{-1,   100, 60},
        '{-1,   100, 60}
    };

    circular_next_free_slot_allocator_core i_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .func          (func),
        .spot          (spot),
        .done          (done),
        .assigned_spot (assigned_spot),
        .full_res      (full_res),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data)
    );

    // Free-running clock
    initial
    begin
        clk = 1'b0;
        forever #(CLK_HALF) clk = ~clk;
    end

    // Usable slots: counts above capacity act as capacity
    function automatic int usable_slots();
        return (int'(spot_limit) > MAX_SPOTS) ? MAX_SPOTS : int'(spot_limit);
    endfunction

    // Compute the grant for one request and update the slot map
    task automatic predict_grant(input logic req_func, input logic [SLOT_W-1:0] req_spot,
                                 output grant_t grant);
        int count;
        int first;
        int k;
        count = usable_slots();
        grant = '0;
        if (req_func == FUNC_ENTER)
        begin
            first = (req_spot == 0) ? 1 : int'(req_spot);
            if (count != 0)
            begin
                // search upward from the preferred slot, then wrap to slot 1
                if (first <= count)
                    for (k = first; k <= count && grant.slot == 0; k++)
                        if (!slot_used[k])
                            grant.slot = SLOT_W'(k);
                for (k = 1; k <= count && grant.slot == 0; k++)
                    if (!slot_used[k])
                        grant.slot = SLOT_W'(k);
            end
            if (grant.slot == 0)
                grant.full = 1'b1;
            else
                slot_used[grant.slot] = 1'b1;
        end
        else if (req_spot >= 1 && int'(req_spot) <= count)
        begin
            slot_used[req_spot] = 1'b0;
        end
    endtask

    // Present one request after an idle gap; hold it until taken, then log its grant
    task automatic issue_request(input logic req_func, input logic [SLOT_W-1:0] req_spot,
                                 input int gap, input logic typed, input grant_t typed_grant);
        grant_t grant;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        func  <= req_func;
        spot  <= req_spot;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        predict_grant(req_func, req_spot, grant);
        expected_grants.push_back(typed ? typed_grant : grant);
    endtask

    // Drop start and wait until every outstanding request has returned
    task automatic drain_requests();
        start <= 1'b0;
        while (expected_grants.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Write spot_count; this frees every slot
    task automatic write_spot_count(input logic [SLOT_W-1:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        spot_limit  = value;
        slot_used   = '0;
    endtask

    // Idle cycles before a request: mostly none or short, a few long
    function automatic int pick_gap(input bit steady);
        int r;
        r = $urandom_range(99);
        if (steady || r < 50)
            return 0;
        if (r < 92)
            return $urandom_range(3, 1);
        return $urandom_range(40, 8);
    endfunction

    // Slot field: mostly in range, else zero, above the count, or any 11-bit value
    function automatic logic [SLOT_W-1:0] pick_spot(input int count);
        int r;
        r = $urandom_range(99);
        if (r < 80 && count != 0)
            return SLOT_W'($urandom_range(count, 1));
        if (r < 88)
            return '0;
        if (r < 94 && count < 2047)
            return SLOT_W'($urandom_range(2047, count + 1));
        return SLOT_W'($urandom_range(2047, 0));
    endfunction

    // Compare each result strobe with the oldest outstanding grant
    always @(posedge clk)
    begin
        grant_t want;
        if (rst_n && done)
        begin
            if (expected_grants.size() == 0)
            begin
                $error("unrequested result: assigned_spot %0d full_res %0b",
                       assigned_spot, full_res);
                mismatches++;
            end
            else
            begin
                want = expected_grants.pop_front();
                if (assigned_spot !== want.slot)
                begin
                    $error("assigned_spot: expected %0d, actual %0d", want.slot, assigned_spot);
                    mismatches++;
                end
                if (full_res !== want.full)
                begin
                    $error("full_res: expected %0b, actual %0b", want.full, full_res);
                    mismatches++;
                end
            end
        end
    end

    // Stimulus: reset, directed table, random phases, final drain
    initial
    begin
        step_row_t         row;
        int                count;
        bit                steady;
        logic              req_func;
        mismatches  = 0;
        spot_limit  = SLOT_W'(MAX_SPOTS);
        slot_used   = '0;
        rst_n       = 1'b0;
        start       = 1'b0;
        func        = FUNC_ENTER;
        spot        = '0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            row = directed_rows[i];
            if (row.kind == ROW_CONFIG)
            begin
                drain_requests();
                write_spot_count(row.spot);
            end
            else
            begin
                issue_request(row.func, row.spot, pick_gap(1'b0), 1'b1,
                              grant_t'{row.exp_spot, row.exp_full});
            end
        end

        foreach (phases[p])
        begin
            drain_requests();
            count = (phases[p].count < 0) ? $urandom_range(2047, 0) : phases[p].count;
            write_spot_count(SLOT_W'(count));
            steady = ($urandom_range(3) == 0);
            repeat (phases[p].items)
            begin
                req_func = ($urandom_range(99) < phases[p].enter_pct) ? FUNC_ENTER : FUNC_LEAVE;
                issue_request(req_func, pick_spot(usable_slots()), pick_gap(steady),
                              1'b0, '0);
            end
        end

        drain_requests();
        repeat (DRAIN_WAIT) @(posedge clk);
        if (mismatches == 0)
            $display("** circular_next_free_slot_allocator_core: PASSED **");
        else
            $display("** circular_next_free_slot_allocator_core: FAILED **");
        $finish;
    end

    // Watchdog: a hung handshake ends the run
    initial
    begin
        #(20_000_000);
        $display("** circular_next_free_slot_allocator_core: FAILED **");
        $finish;
    end

endmodule
